@@ rtl/bffa_pkg.sv @@
`default_nettype none
package bffa_pkg;

  localparam int GROUPS          = 16;
  localparam int BYTES_PER_GROUP = 1024;
  localparam int STORE_BYTES     = GROUPS * BYTES_PER_GROUP;
  localparam int BIT_LIMIT       = BYTES_PER_GROUP * 8;

  localparam int ADDR_W  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int GRP_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int BYTE_W  = (BYTES_PER_GROUP > 1) ? $clog2(BYTES_PER_GROUP) : 1;
  localparam int GCNT_W  = $clog2(GROUPS + 1);
  localparam int BITS_W  = $clog2(BIT_LIMIT + 1);
  localparam int NB_W    = $clog2(BYTES_PER_GROUP + 1);

  localparam int IPG_W   = 14;
  localparam int GC_W    = 5;
  localparam int IPG_RST = 8192;
  localparam int GC_RST  = 16;

  localparam int IN_ADDR_W   = 14;
  localparam int VAL_W       = 8;
  localparam int NUM_W       = 18;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CLAIM = 1'b1;

  localparam logic REG_IPG = 1'b0;
  localparam logic REG_GC  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLAIMED = 2'd0,
    ST_FULL    = 2'd1,
    ST_LOAD    = 2'd2
  } status_t;

  typedef struct packed {
    logic [IPG_W-1:0] ipg;
    logic [GC_W-1:0]  gc;
  } cfg_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    status_t          status;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/bffa_ram.sv @@
`default_nettype none
module bffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/bffa_cfg.sv @@
`default_nettype none
module bffa_cfg
  import bffa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [IPG_W-1:0] ipg_r, ipg_nxt;
  logic [GC_W-1:0]  gc_r, gc_nxt;
  logic             wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_comb begin
    ipg_nxt = ipg_r;
    gc_nxt  = gc_r;
    if (wr) begin
      case (paddr[2])
        REG_IPG: ipg_nxt = pwdata[IPG_W-1:0];
        REG_GC:  gc_nxt  = pwdata[GC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ipg_r <= IPG_W'(IPG_RST);
      gc_r  <= GC_W'(GC_RST);
    end else begin
      ipg_r <= ipg_nxt;
      gc_r  <= gc_nxt;
    end
  end

  assign prdata  = (paddr[2] == REG_GC) ? CFG_DW'(gc_r) : CFG_DW'(ipg_r);
  assign cfg.ipg = ipg_r;
  assign cfg.gc  = gc_r;

endmodule
`default_nettype wire

@@ rtl/bffa_ctrl.sv @@
`default_nettype none
module bffa_ctrl
  import bffa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cfg_t                 cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 op,
  input  wire logic [IN_ADDR_W-1:0] byte_address,
  input  wire logic [VAL_W-1:0]     byte_value,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output res_t                      res
);

  typedef enum logic [1:0] {CLR, IDLE, SCAN, DONE} state_t;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [GRP_W-1:0]   iss_grp_r, iss_grp_nxt;
  logic [BYTE_W-1:0]  iss_byte_r, iss_byte_nxt;
  logic [NUM_W-1:0]   iss_base_r, iss_base_nxt;
  logic               iss_done_r, iss_done_nxt;
  logic               chk_v_r, chk_v_nxt;
  logic               chk_last_r, chk_last_nxt;
  logic [BYTE_W-1:0]  chk_byte_r, chk_byte_nxt;
  logic [NUM_W-1:0]   chk_base_r, chk_base_nxt;
  logic [ADDR_W-1:0]  chk_addr_r, chk_addr_nxt;
  res_t               res_r, res_nxt;

  logic [GCNT_W-1:0]  grp_lim;
  logic [BITS_W-1:0]  bits_eff;
  logic [NB_W-1:0]    nbytes;
  logic [BITS_W-1:0]  rem;
  logic [VAL_W-1:0]   vmask;
  logic [VAL_W-1:0]   probe;
  logic [2:0]         bitpos;
  logic               hit;
  logic               last_byte;
  logic               last_grp;
  logic [ADDR_W-1:0]  iss_addr;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [VAL_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [VAL_W-1:0]   ram_rdata;

  bffa_ram #(
    .WIDTH(VAL_W),
    .DEPTH(STORE_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(iss_addr),
    .rdata(ram_rdata)
  );

  assign grp_lim  = (int'(cfg.gc) > GROUPS) ? GCNT_W'(GROUPS) : GCNT_W'(cfg.gc);
  assign bits_eff = (int'(cfg.ipg) > BIT_LIMIT) ? BITS_W'(BIT_LIMIT) : BITS_W'(cfg.ipg);
  assign nbytes   = NB_W'(((BITS_W + 1)'(bits_eff) + (BITS_W + 1)'(7)) >> 3);

  assign iss_addr  = ADDR_W'(iss_grp_r) * ADDR_W'(BYTES_PER_GROUP) + ADDR_W'(iss_byte_r);
  assign last_byte = (NB_W'(iss_byte_r) == nbytes - NB_W'(1));
  assign last_grp  = (GCNT_W'(iss_grp_r) == grp_lim - GCNT_W'(1));

  assign rem   = bits_eff - BITS_W'({chk_byte_r, 3'b000});
  assign vmask = (rem >= BITS_W'(8)) ? {VAL_W{1'b1}}
                                     : VAL_W'((9'd1 << rem[3:0]) - 9'd1);
  assign probe = ram_rdata | ~vmask;
  assign hit   = (probe != {VAL_W{1'b1}});

  always_comb begin
    bitpos = 3'd0;
    for (int i = VAL_W - 1; i >= 0; i--) begin
      if (!probe[i]) begin
        bitpos = 3'(i);
      end
    end
  end

  assign in_ready  = (state_r == IDLE);
  assign res_valid = (state_r == DONE);
  assign res       = res_r;
  assign ram_re    = (state_r == SCAN) && !iss_done_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_addr_r;
    ram_wdata = ram_rdata | VAL_W'(8'd1 << bitpos);
    case (state_r)
      CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      IDLE: begin
        ram_we    = in_valid && (op == OP_LOAD) && (int'(byte_address) < STORE_BYTES);
        ram_waddr = ADDR_W'(byte_address);
        ram_wdata = byte_value;
      end
      SCAN: ram_we = chk_v_r && hit;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    iss_grp_nxt  = iss_grp_r;
    iss_byte_nxt = iss_byte_r;
    iss_base_nxt = iss_base_r;
    iss_done_nxt = iss_done_r;
    chk_v_nxt    = 1'b0;
    chk_last_nxt = chk_last_r;
    chk_byte_nxt = chk_byte_r;
    chk_base_nxt = chk_base_r;
    chk_addr_nxt = chk_addr_r;
    res_nxt      = res_r;
    case (state_r)
      CLR: begin
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(STORE_BYTES - 1)) begin
          state_nxt = IDLE;
        end
      end
      IDLE: begin
        if (in_valid) begin
          if (op == OP_LOAD) begin
            res_nxt   = '{num: '0, status: ST_LOAD};
            state_nxt = DONE;
          end else if (grp_lim == '0 || bits_eff == '0) begin
            res_nxt   = '{num: '0, status: ST_FULL};
            state_nxt = DONE;
          end else begin
            iss_grp_nxt  = '0;
            iss_byte_nxt = '0;
            iss_base_nxt = '0;
            iss_done_nxt = 1'b0;
            state_nxt    = SCAN;
          end
        end
      end
      SCAN: begin
        if (!iss_done_r) begin
          chk_v_nxt    = 1'b1;
          chk_byte_nxt = iss_byte_r;
          chk_base_nxt = iss_base_r;
          chk_addr_nxt = iss_addr;
          chk_last_nxt = last_byte && last_grp;
          if (last_byte) begin
            iss_byte_nxt = '0;
            if (last_grp) begin
              iss_done_nxt = 1'b1;
            end else begin
              iss_grp_nxt  = iss_grp_r + GRP_W'(1);
              iss_base_nxt = iss_base_r + NUM_W'(cfg.ipg);
            end
          end else begin
            iss_byte_nxt = iss_byte_r + BYTE_W'(1);
          end
        end
        if (chk_v_r) begin
          if (hit) begin
            res_nxt.num    = chk_base_r + NUM_W'({chk_byte_r, bitpos}) + NUM_W'(1);
            res_nxt.status = ST_CLAIMED;
            chk_v_nxt      = 1'b0;
            state_nxt      = DONE;
          end else if (chk_last_r) begin
            res_nxt   = '{num: '0, status: ST_FULL};
            chk_v_nxt = 1'b0;
            state_nxt = DONE;
          end
        end
      end
      DONE: begin
        if (res_ready) begin
          state_nxt = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= CLR;
      clr_cnt_r <= '0;
      chk_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      chk_v_r   <= chk_v_nxt;
    end
    iss_grp_r  <= iss_grp_nxt;
    iss_byte_r <= iss_byte_nxt;
    iss_base_r <= iss_base_nxt;
    iss_done_r <= iss_done_nxt;
    chk_last_r <= chk_last_nxt;
    chk_byte_r <= chk_byte_nxt;
    chk_base_r <= chk_base_nxt;
    chk_addr_r <= chk_addr_nxt;
    res_r      <= res_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/bitmap_first_free_allocator.sv @@
// First-free object allocator over a grouped bitmap held in one byte-wide
// synchronous RAM. After reset the block sweeps the whole RAM to zero, one
// byte a cycle, with in_tready low; register writes are taken throughout. A
// load word writes one bitmap byte and its result passes through the result
// register and then the output register. A claim word reads the bitmap one
// byte per cycle from group 0, byte 0, over at most group_count groups of
// ceil(inodes_per_group / 8) bytes; the single RAM read port sets that rate.
// The next word is accepted once the result has moved into the output
// register, which holds it until taken.
`default_nettype none
module bitmap_first_free_allocator
  import bffa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // byte_address[13:0], byte_value[21:14]
  input  wire logic [0:0]             in_tuser,   // operation[0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // object_number[17:0]
  output logic      [1:0]             out_tuser,  // status[1:0]
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_AW-1:0]      cfg_paddr,
  input  wire logic [CFG_DW-1:0]      cfg_pwdata,
  output logic      [CFG_DW-1:0]      cfg_prdata,
  output logic                        cfg_pready
);

  cfg_t cfg;
  res_t res;
  res_t out_res_r, out_res_nxt;
  logic res_valid;
  logic res_ready;
  logic out_valid_r, out_valid_nxt;

  bffa_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (cfg_psel),
    .penable(cfg_penable),
    .pwrite (cfg_pwrite),
    .paddr  (cfg_paddr),
    .pwdata (cfg_pwdata),
    .prdata (cfg_prdata),
    .pready (cfg_pready),
    .cfg    (cfg)
  );

  bffa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .op          (in_tuser[0]),
    .byte_address(in_tdata[IN_ADDR_W-1:0]),
    .byte_value  (in_tdata[IN_ADDR_W +: VAL_W]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_res_r.num);
  assign out_tuser  = out_res_r.status;

endmodule
`default_nettype wire

@@ rtl/bffa_checker.sv @@
`default_nettype none
module bffa_checker
  import bffa_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [1:0]             out_tuser
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  // one word in flight: drop ready after each accepted word
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  a_claim_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_CLAIMED |-> out_tdata != '0)
    else $error("claim returned object number zero");

  a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_CLAIMED |-> out_tdata == '0 &&
      (out_tuser == ST_FULL || out_tuser == ST_LOAD))
    else $error("bad load or full result word");

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
`default_nettype wire
